// ===== design/line_assembler_with_stop_word_assert.svh =====
`ifndef LINE_ASSEMBLER_WITH_STOP_WORD_ASSERT_SVH
`define LINE_ASSEMBLER_WITH_STOP_WORD_ASSERT_SVH

// condition must never hold at a clock edge
`define LASW_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define LASW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/lasw_pkg.sv =====
package lasw_pkg;

	localparam int LINE_BYTES = 64;
	localparam int CNT_W      = $clog2(LINE_BYTES);
	localparam int ADDR_W     = CNT_W + 1;

	localparam int CQ_DEPTH  = 2;
	localparam int CQ_PTR_W  = $clog2(CQ_DEPTH);
	localparam int CQ_CNT_W  = $clog2(CQ_DEPTH + 1);
	localparam int RQ_DEPTH  = 4;
	localparam int RQ_PTR_W  = $clog2(RQ_DEPTH);
	localparam int RQ_LVL_W  = $clog2(RQ_DEPTH + 1);

	localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(LINE_BYTES - 1);

	localparam int STOP_LEN = 4;
	localparam int DST_LEN  = 5;

	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_S      = 8'h73;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_O      = 8'h6f;
	localparam logic [7:0] CH_P      = 8'h70;
	localparam logic [7:0] CH_D      = 8'h64;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UZ     = 8'h5a;
	localparam logic [7:0] CASE_OFS  = 8'h20;

	typedef enum logic [1:0] {
		OP_BYTE      = 2'd0,
		OP_TAKE_LINE = 2'd1,
		OP_TAKE_STOP = 2'd2,
		OP_TAKE_OVF  = 2'd3
	} op_t;

	typedef enum logic {
		BK_IDLE,
		BK_STREAM
	} back_state_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] rx_byte;
		logic [7:0] read_limit;
		logic       is_eol;
		logic       ends;
	} cmd_t;

	typedef struct packed {
		logic       took;
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       last;
		logic       stop_pending;
		logic       overflow_pending;
		logic       line_waiting;
	} res_t;

	function automatic logic [7:0] fold_case(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= CH_UA && c <= CH_UZ)
			r = c + CASE_OFS;
		return r;
	endfunction

	function automatic logic [7:0] stop_char(input logic [1:0] idx);
		logic [7:0] r;
		unique case (idx)
			2'd0: r = CH_S;
			2'd1: r = CH_T;
			2'd2: r = CH_O;
			2'd3: r = CH_P;
			default: r = CH_S;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] dst_char(input logic [2:0] idx);
		logic [7:0] r;
		unique case (idx)
			3'd0: r = CH_DOLLAR;
			3'd1: r = CH_D;
			3'd2: r = CH_S;
			3'd3: r = CH_T;
			3'd4: r = CH_BANG;
			default: r = CH_DOLLAR;
		endcase
		return r;
	endfunction

endpackage

// ===== design/lasw_front.sv =====
module lasw_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  logic [1:0]     operation,
	input  logic [7:0]     rx_byte,
	input  logic [7:0]     read_limit,
	output logic           full,
	output logic           cmd_valid,
	output lasw_pkg::cmd_t cmd,
	input  logic           cmd_take
);
	import lasw_pkg::*;

	cmd_t                q_q [CQ_DEPTH];
	logic [CQ_PTR_W-1:0] wr_ptr_q;
	logic [CQ_PTR_W-1:0] rd_ptr_q;
	logic [CQ_CNT_W-1:0] cnt_q;
	cmd_t                new_cmd;
	logic                acc;
	logic                take;

	always_comb begin
		new_cmd.op         = op_t'(operation);
		new_cmd.rx_byte    = rx_byte;
		new_cmd.read_limit = read_limit;
		new_cmd.is_eol     = (rx_byte == CH_CR) || (rx_byte == CH_LF);
		new_cmd.ends       = new_cmd.is_eol || (rx_byte == CH_BANG);
	end

	assign full      = (cnt_q == CQ_CNT_W'(CQ_DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = q_q[rd_ptr_q];
	assign acc       = push && !full;
	assign take      = cmd_take && cmd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (acc)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (take)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + CQ_CNT_W'(acc) - CQ_CNT_W'(take);
		end
	end

	always_ff @(posedge clk) begin
		if (acc)
			q_q[wr_ptr_q] <= new_cmd;
	end

endmodule

// ===== design/lasw_back.sv =====
module lasw_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	input  lasw_pkg::cmd_t                cmd,
	output logic                          cmd_take,
	input  logic [lasw_pkg::RQ_LVL_W-1:0] rq_level,
	output logic                          res_push,
	output lasw_pkg::res_t                res
);
	import lasw_pkg::*;

	// two line banks; the held line is the bank not being assembled
	logic [7:0]        mem_q [2*LINE_BYTES];

	back_state_t       state_q, state_d;
	logic [CNT_W-1:0]  acount_q, acount_d;
	logic [CNT_W-1:0]  hcount_q, hcount_d;
	logic              held_q, held_d;
	logic              stop_q, stop_d;
	logic              ovf_q, ovf_d;
	logic              cls_q, cls_d;
	logic              pstop_q, pstop_d;
	logic              pdst_q, pdst_d;
	logic              abank_q, abank_d;
	logic [CNT_W-1:0]  rd_idx_q, rd_idx_d;
	logic [CNT_W-1:0]  rd_last_q, rd_last_d;

	logic              res_vld_s1;
	res_t              meta_s1;
	logic [7:0]        rdata_s1;

	logic              room;
	logic              emit;
	logic              emit_mem;
	logic              took;
	logic              last;
	logic              wr_en;
	logic [ADDR_W-1:0] rd_addr;

	logic [CNT_W-1:0]  c;
	logic [7:0]        fb;
	logic              app, drop, stop_n, dst_n, hit, cls2, finish;
	logic [CNT_W-1:0]  cnt1;
	logic [7:0]        lim_m1, hc8, n8;
	logic [CNT_W-1:0]  n;
	logic              tl_ok;

	assign room = (rq_level + RQ_LVL_W'(res_vld_s1)) < RQ_LVL_W'(RQ_DEPTH);

	assign c      = acount_q;
	assign fb     = fold_case(cmd.rx_byte);
	assign app    = !cmd.is_eol && (c != LAST_IDX);
	assign drop   = !cmd.is_eol && (c == LAST_IDX);
	assign stop_n = app && (c < CNT_W'(STOP_LEN)) && ((c == '0) || pstop_q)
	                && (fb == stop_char(c[1:0]));
	assign dst_n  = app && (c < CNT_W'(DST_LEN)) && ((c == '0) || pdst_q)
	                && (fb == dst_char(c[2:0]));
	assign hit    = app ? ((stop_n && c == CNT_W'(STOP_LEN - 1)) ||
	                       (dst_n && c == CNT_W'(DST_LEN - 1)))
	                    : (cmd.is_eol && c == CNT_W'(STOP_LEN) && pstop_q);
	assign cnt1   = app ? c + 1'b1 : (drop ? '0 : c);
	assign cls2   = (drop ? 1'b0 : cls_q) | hit;
	assign finish = cmd.ends && (cnt1 != '0) && !cls2;

	assign lim_m1 = cmd.read_limit - 8'd1;
	assign hc8    = 8'(hcount_q);
	assign n8     = (hc8 > lim_m1) ? lim_m1 : hc8;
	assign n      = CNT_W'(n8);
	assign tl_ok  = held_q && (cmd.read_limit != 8'd0);

	always_comb begin
		state_d   = state_q;
		acount_d  = acount_q;
		hcount_d  = hcount_q;
		held_d    = held_q;
		stop_d    = stop_q;
		ovf_d     = ovf_q;
		cls_d     = cls_q;
		pstop_d   = pstop_q;
		pdst_d    = pdst_q;
		abank_d   = abank_q;
		rd_idx_d  = rd_idx_q;
		rd_last_d = rd_last_q;
		cmd_take  = 1'b0;
		emit      = 1'b0;
		emit_mem  = 1'b0;
		took      = 1'b0;
		last      = 1'b1;
		wr_en     = 1'b0;
		rd_addr   = {~abank_q, rd_idx_q};
		unique case (state_q)
			BK_IDLE: begin
				if (cmd_valid && room) begin
					cmd_take = 1'b1;
					unique case (cmd.op)
						OP_BYTE: begin
							emit   = 1'b1;
							wr_en  = app;
							stop_d = stop_q | hit;
							ovf_d  = ovf_q | drop | (finish && held_q);
							if (app) begin
								pstop_d = stop_n;
								pdst_d  = dst_n;
							end
							if (cmd.ends) begin
								acount_d = '0;
								cls_d    = 1'b0;
								if (finish && !held_q) begin
									hcount_d = cnt1;
									held_d   = 1'b1;
									abank_d  = ~abank_q;
								end
							end else begin
								acount_d = cnt1;
								cls_d    = cls2;
							end
						end
						OP_TAKE_LINE: begin
							took = tl_ok;
							if (tl_ok) begin
								held_d   = 1'b0;
								hcount_d = '0;
							end
							if (tl_ok && n != '0) begin
								state_d   = BK_STREAM;
								rd_idx_d  = '0;
								rd_last_d = n - 1'b1;
							end else begin
								emit = 1'b1;
							end
						end
						OP_TAKE_STOP: begin
							emit   = 1'b1;
							took   = stop_q;
							stop_d = 1'b0;
						end
						OP_TAKE_OVF: begin
							emit  = 1'b1;
							took  = ovf_q;
							ovf_d = 1'b0;
						end
					endcase
				end
			end
			BK_STREAM: begin
				if (room) begin
					emit     = 1'b1;
					emit_mem = 1'b1;
					took     = 1'b1;
					last     = (rd_idx_q == rd_last_q);
					if (last)
						state_d = BK_IDLE;
					else
						rd_idx_d = rd_idx_q + 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_IDLE;
			acount_q   <= '0;
			hcount_q   <= '0;
			held_q     <= 1'b0;
			stop_q     <= 1'b0;
			ovf_q      <= 1'b0;
			cls_q      <= 1'b0;
			pstop_q    <= 1'b0;
			pdst_q     <= 1'b0;
			abank_q    <= 1'b0;
			rd_idx_q   <= '0;
			rd_last_q  <= '0;
			res_vld_s1 <= 1'b0;
		end else begin
			state_q    <= state_d;
			acount_q   <= acount_d;
			hcount_q   <= hcount_d;
			held_q     <= held_d;
			stop_q     <= stop_d;
			ovf_q      <= ovf_d;
			cls_q      <= cls_d;
			pstop_q    <= pstop_d;
			pdst_q     <= pdst_d;
			abank_q    <= abank_d;
			rd_idx_q   <= rd_idx_d;
			rd_last_q  <= rd_last_d;
			res_vld_s1 <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[{abank_q, c}] <= cmd.rx_byte;
		if (emit_mem)
			rdata_s1 <= mem_q[rd_addr];
		if (emit) begin
			meta_s1.took             <= took;
			meta_s1.data_byte        <= 8'd0;
			meta_s1.byte_valid       <= emit_mem;
			meta_s1.last             <= last;
			meta_s1.stop_pending     <= stop_d;
			meta_s1.overflow_pending <= ovf_d;
			meta_s1.line_waiting     <= held_d;
		end
	end

	always_comb begin
		res = meta_s1;
		if (meta_s1.byte_valid)
			res.data_byte = rdata_s1;
	end

	assign res_push = res_vld_s1;

endmodule

// ===== design/lasw_resq.sv =====
module lasw_resq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          res_push,
	input  lasw_pkg::res_t                res_in,
	input  logic                          pop,
	output logic                          empty,
	output lasw_pkg::res_t                head,
	output logic [lasw_pkg::RQ_LVL_W-1:0] level
);
	import lasw_pkg::*;

	res_t                q_q [RQ_DEPTH];
	logic [RQ_PTR_W-1:0] wr_ptr_q;
	logic [RQ_PTR_W-1:0] rd_ptr_q;
	logic [RQ_LVL_W-1:0] lvl_q;
	logic                take;

	assign empty = (lvl_q == '0);
	assign level = lvl_q;
	assign head  = q_q[rd_ptr_q];
	assign take  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			lvl_q    <= '0;
		end else begin
			if (res_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (take)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			lvl_q <= lvl_q + RQ_LVL_W'(res_push) - RQ_LVL_W'(take);
		end
	end

	always_ff @(posedge clk) begin
		if (res_push)
			q_q[wr_ptr_q] <= res_in;
	end

endmodule

// ===== design/line_assembler_with_stop_word.sv =====
// Gathers received bytes into lines ending at CR, LF or '!', detects the stop words
// "stop" and "$dst!", and hands finished lines to a single hold slot that take items read out.
// A two-item command queue feeds the execution back end; results leave through a four-entry
// result queue, so a new item is taken while earlier results wait. In the back end a received
// byte, a flag take or a take-line item that copies no characters is done in the idle state; a
// take-line item that copies n characters passes a start state and then reads one character per
// cycle, while the result queue has room, through the single read port of the line memory. A
// result passes the command queue, the back end's result register and the result queue, a line
// character also the read register of the line memory; the back end stalls while the result
// queue has no free entry. Line handoff is a bank swap; no memory clearing is done after reset.
`include "line_assembler_with_stop_word_assert.svh"

module line_assembler_with_stop_word (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [1:0] operation,
	input  logic [7:0] rx_byte,
	input  logic [7:0] read_limit,
	output logic       empty,
	input  logic       pop,
	output logic       took,
	output logic [7:0] data_byte,
	output logic       byte_valid,
	output logic       last,
	output logic       stop_pending,
	output logic       overflow_pending,
	output logic       line_waiting
);
	import lasw_pkg::*;

	logic                cmd_valid;
	cmd_t                cmd;
	logic                cmd_take;
	logic [RQ_LVL_W-1:0] rq_level;
	logic                res_push;
	res_t                res;
	res_t                head;

	lasw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.operation  (operation),
		.rx_byte    (rx_byte),
		.read_limit (read_limit),
		.full       (full),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_take   (cmd_take)
	);

	lasw_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.rq_level  (rq_level),
		.res_push  (res_push),
		.res       (res)
	);

	lasw_resq u_resq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_in   (res),
		.pop      (pop),
		.empty    (empty),
		.head     (head),
		.level    (rq_level)
	);

	assign took             = head.took;
	assign data_byte        = head.data_byte;
	assign byte_valid       = head.byte_valid;
	assign last             = head.last;
	assign stop_pending     = head.stop_pending;
	assign overflow_pending = head.overflow_pending;
	assign line_waiting     = head.line_waiting;

	`LASW_ASSERT_NEVER(a_rq_no_overrun, res_push && rq_level == RQ_LVL_W'(RQ_DEPTH), "result queue overrun")
	`LASW_ASSERT_NEVER(a_char_slot_free, !empty && byte_valid && line_waiting, "line char with slot busy")
	`LASW_ASSERT_NEVER(a_char_took, !empty && byte_valid && !took, "line char without took")
	`LASW_ASSERT_NEXT(a_take_consumes, cmd_take, !(cmd_valid && cmd_take && full && !push), "cmd queue stuck")

endmodule

// ===== tb/line_assembler_with_stop_word_test.sv =====
`default_nettype none

module line_assembler_with_stop_word_test;
	timeunit 1ns;
	timeprecision 1ps;

	import lasw_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 20;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [1:0] operation = OP_BYTE;
	logic [7:0] rx_byte = 8'h00;
	logic [7:0] read_limit = 8'h00;
	logic       empty;
	logic       pop = 1'b0;
	logic       took;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       last;
	logic       stop_pending;
	logic       overflow_pending;
	logic       line_waiting;

	line_assembler_with_stop_word i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.operation(operation),
		.rx_byte(rx_byte),
		.read_limit(read_limit),
		.empty(empty),
		.pop(pop),
		.took(took),
		.data_byte(data_byte),
		.byte_valid(byte_valid),
		.last(last),
		.stop_pending(stop_pending),
		.overflow_pending(overflow_pending),
		.line_waiting(line_waiting)
	);

	always #5 clk = ~clk;

	// line state mirror
	logic [7:0]  partial_text [LINE_BYTES];
	logic [7:0]  held_text [LINE_BYTES];
	int unsigned partial_len = 0;
	int unsigned held_len = 0;
	bit          held_full = 1'b0;
	bit          stop_req = 1'b0;
	bit          line_killed = 1'b0;
	bit          ovf_seen = 1'b0;

	res_t        pending_results[$];

	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          items_sent = 0;
	int          results_seen = 0;
	int          mismatches = 0;
	int          lines_read = 0;
	int          stops_cleared = 0;
	int          overflows_cleared = 0;
	int          cycle_count = 0;

	function automatic logic [7:0] to_lower(logic [7:0] c);
		if (c >= CH_UA && c <= CH_UZ)
			return c + CASE_OFS;
		return c;
	endfunction

	function automatic bit partial_is_stop_word();
		if (partial_len == STOP_LEN && to_lower(partial_text[0]) == CH_S &&
				to_lower(partial_text[1]) == CH_T && to_lower(partial_text[2]) == CH_O &&
				to_lower(partial_text[3]) == CH_P)
			return 1'b1;
		if (partial_len == DST_LEN && partial_text[0] == CH_DOLLAR &&
				to_lower(partial_text[1]) == CH_D && to_lower(partial_text[2]) == CH_S &&
				to_lower(partial_text[3]) == CH_T && partial_text[4] == CH_BANG)
			return 1'b1;
		return 1'b0;
	endfunction

	task automatic absorb_byte(logic [7:0] b);
		bit eol;
		bit ends;
		eol = (b == CH_CR) || (b == CH_LF);
		ends = eol || (b == CH_BANG);
		if (!eol) begin
			if (partial_len < LINE_BYTES - 1) begin
				partial_text[partial_len] = b;
				partial_len++;
			end else begin
				ovf_seen = 1'b1;
				partial_len = 0;
				line_killed = 1'b0;
			end
		end
		if (partial_is_stop_word()) begin
			stop_req = 1'b1;
			line_killed = 1'b1;
		end
		if (ends) begin
			if (partial_len != 0 && !line_killed) begin
				if (!held_full) begin
					held_len = partial_len;
					for (int i = 0; i < held_len; i++)
						held_text[i] = partial_text[i];
					held_full = 1'b1;
				end else begin
					ovf_seen = 1'b1;
				end
			end
			partial_len = 0;
			line_killed = 1'b0;
		end
	endtask

	task automatic predict_results(op_t op, logic [7:0] b, logic [7:0] lim);
		int unsigned n;
		int unsigned cnt;
		bit          took_it;
		res_t        r;
		n = 0;
		took_it = 1'b0;
		case (op)
			OP_BYTE: begin
				absorb_byte(b);
			end
			OP_TAKE_LINE: begin
				if (held_full && lim != 0) begin
					n = held_len;
					if (n >= lim)
						n = lim - 1;
					held_len = 0;
					held_full = 1'b0;
					took_it = 1'b1;
					lines_read++;
				end
			end
			OP_TAKE_STOP: begin
				if (stop_req) begin
					stop_req = 1'b0;
					took_it = 1'b1;
					stops_cleared++;
				end
			end
			default: begin
				if (ovf_seen) begin
					ovf_seen = 1'b0;
					took_it = 1'b1;
					overflows_cleared++;
				end
			end
		endcase
		cnt = (n == 0) ? 1 : n;
		for (int k = 0; k < cnt; k++) begin
			r.took = took_it;
			r.data_byte = (n == 0) ? 8'h00 : held_text[k];
			r.byte_valid = (n != 0);
			r.last = (k + 1 == cnt);
			r.stop_pending = stop_req;
			r.overflow_pending = ovf_seen;
			r.line_waiting = held_full;
			pending_results.push_back(r);
		end
	endtask

	task automatic send_item(op_t op, logic [7:0] b, logic [7:0] lim);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		operation <= op;
		rx_byte <= b;
		read_limit <= lim;
		do
			@(posedge clk);
		while (full);
		predict_results(op, b, lim);
		items_sent++;
	endtask

	task automatic check_field(string what, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %0h, got %0h", $time, what, want, got);
		end
	endtask

	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && pop && !empty) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				$display("%0t: result with none expected, took %0b data %0h valid %0b last %0b",
					$time, took, data_byte, byte_valid, last);
			end else begin
				want = pending_results.pop_front();
				check_field("took", want.took, took);
				check_field("data_byte", want.data_byte, data_byte);
				check_field("byte_valid", want.byte_valid, byte_valid);
				check_field("last", want.last, last);
				check_field("stop_pending", want.stop_pending, stop_pending);
				check_field("overflow_pending", want.overflow_pending, overflow_pending);
				check_field("line_waiting", want.line_waiting, line_waiting);
			end
		end
		pop <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still outstanding", $time,
				pending_results.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	function automatic logic [7:0] text_byte();
		logic [7:0] c;
		do
			c = 8'($urandom);
		while (c == CH_CR || c == CH_LF || c == CH_BANG);
		return c;
	endfunction

	function automatic logic [7:0] any_case(logic [7:0] c);
		return $urandom_range(1) ? c - CASE_OFS : c;
	endfunction

	function automatic logic [7:0] pick_limit();
		case ($urandom_range(9))
			0: return 8'd0;
			1: return 8'd1;
			2, 3, 4: return 8'($urandom_range(10, 2));
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_item(OP_BYTE, s[i], 8'($urandom));
	endtask

	task automatic send_fill(int n);
		for (int i = 0; i < n; i++)
			send_item(OP_BYTE, text_byte(), 8'($urandom));
	endtask

	task automatic take(op_t op, logic [7:0] lim);
		send_item(op, 8'($urandom), lim);
	endtask

	task automatic test_nothing_to_take();
		take(OP_TAKE_LINE, 8'd5);
		take(OP_TAKE_STOP, 8'($urandom));
		take(OP_TAKE_OVF, 8'($urandom));
		take(OP_TAKE_LINE, 8'd0);
	endtask

	task automatic test_stop_words();
		send_text("StOp");
		send_item(OP_BYTE, CH_CR, 8'($urandom));
		take(OP_TAKE_STOP, 8'($urandom));
		send_text("$DsT!");
		take(OP_TAKE_LINE, 8'hff);
		take(OP_TAKE_STOP, 8'($urandom));
		take(OP_TAKE_STOP, 8'($urandom));
	endtask

	task automatic test_read_limits();
		send_item(OP_BYTE, 8'h00, 8'h00);
		send_item(OP_BYTE, 8'hff, 8'hff);
		send_item(OP_BYTE, CH_BANG, 8'($urandom));
		take(OP_TAKE_LINE, 8'd0);
		take(OP_TAKE_LINE, 8'hff);
		send_text("ab");
		send_item(OP_BYTE, CH_LF, 8'($urandom));
		take(OP_TAKE_LINE, 8'd1);
		send_text("xyz");
		send_item(OP_BYTE, CH_LF, 8'($urandom));
		take(OP_TAKE_LINE, 8'd2);
	endtask

	task automatic test_slot_busy();
		send_item(OP_BYTE, CH_LF, 8'($urandom));
		send_text("a");
		send_item(OP_BYTE, CH_CR, 8'($urandom));
		send_text("b");
		send_item(OP_BYTE, CH_CR, 8'($urandom));
		take(OP_TAKE_OVF, 8'($urandom));
		take(OP_TAKE_LINE, 8'hff);
	endtask

	task automatic test_buffer_full();
		// dropped bang on a full buffer ends an empty line
		send_fill(LINE_BYTES - 1);
		send_item(OP_BYTE, CH_BANG, 8'($urandom));
		take(OP_TAKE_OVF, 8'($urandom));
		send_fill(LINE_BYTES - 1);
		send_text("Q");
		send_item(OP_BYTE, CH_LF, 8'($urandom));
		take(OP_TAKE_LINE, 8'hff);
		take(OP_TAKE_OVF, 8'($urandom));
		send_fill(LINE_BYTES - 1);
		send_item(OP_BYTE, CH_CR, 8'($urandom));
		take(OP_TAKE_LINE, 8'hff);
		send_fill(LINE_BYTES - 1);
		send_item(OP_BYTE, CH_LF, 8'($urandom));
		take(OP_TAKE_LINE, 8'(LINE_BYTES - 1));
	endtask

	task automatic send_random_line();
		int len;
		len = ($urandom_range(24) == 0) ? $urandom_range(70, 55) : $urandom_range(10);
		send_fill(len);
		case ($urandom_range(9))
			0, 1, 2: send_item(OP_BYTE, CH_CR, 8'($urandom));
			3, 4, 5: send_item(OP_BYTE, CH_LF, 8'($urandom));
			6, 7, 8: send_item(OP_BYTE, CH_BANG, 8'($urandom));
			default: ;
		endcase
	endtask

	task automatic send_stop_word();
		if ($urandom_range(5) == 0)
			send_item(OP_BYTE, text_byte(), 8'($urandom));
		if ($urandom_range(1)) begin
			send_item(OP_BYTE, any_case(CH_S), 8'($urandom));
			send_item(OP_BYTE, any_case(CH_T), 8'($urandom));
			send_item(OP_BYTE, any_case(CH_O), 8'($urandom));
			send_item(OP_BYTE, any_case(CH_P), 8'($urandom));
			if ($urandom_range(3) == 0)
				send_item(OP_BYTE, text_byte(), 8'($urandom));
			case ($urandom_range(2))
				0: send_item(OP_BYTE, CH_CR, 8'($urandom));
				1: send_item(OP_BYTE, CH_LF, 8'($urandom));
				default: send_item(OP_BYTE, CH_BANG, 8'($urandom));
			endcase
		end else begin
			send_item(OP_BYTE, CH_DOLLAR, 8'($urandom));
			send_item(OP_BYTE, any_case(CH_D), 8'($urandom));
			send_item(OP_BYTE, any_case(CH_S), 8'($urandom));
			send_item(OP_BYTE, any_case(CH_T), 8'($urandom));
			send_item(OP_BYTE, CH_BANG, 8'($urandom));
		end
	endtask

	task automatic run_random_traffic(int send_pct, int recv_pct, int n_items);
		int target;
		int sel;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		target = items_sent + n_items;
		while (items_sent < target) begin
			sel = $urandom_range(99);
			if (sel < 45)
				send_random_line();
			else if (sel < 55)
				send_stop_word();
			else if (sel < 75)
				take(OP_TAKE_LINE, pick_limit());
			else if (sel < 82)
				take(OP_TAKE_STOP, 8'($urandom));
			else if (sel < 89)
				take(OP_TAKE_OVF, 8'($urandom));
			else
				send_item(op_t'($urandom_range(3)), 8'($urandom), 8'($urandom));
		end
	endtask

	task automatic test_random_slow_sender();
		run_random_traffic(25, 64, 70);
	endtask

	task automatic test_random_slow_reader();
		run_random_traffic(64, 25, 70);
	endtask

	task automatic test_random_full_rate();
		run_random_traffic(0, 0, 60);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 25;
		recv_idle_pct = 64;
		test_nothing_to_take();
		test_stop_words();
		test_read_limits();
		test_slot_busy();
		test_buffer_full();
		test_random_slow_sender();
		test_random_slow_reader();
		test_random_full_rate();
		push <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d items, checked %0d results in %0d cycles.", items_sent,
			results_seen, cycle_count);
		$display("Lines read out %0d, stop requests cleared %0d, overflows cleared %0d.",
			lines_read, stops_cleared, overflows_cleared);
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

`default_nettype wire
